### rtl/fme_pkg.sv
// fme_pkg: shared types and codes for the first match extractor
// input operation codes, result kinds and the command word passed from front to back
// no dependencies
package fme_pkg;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int LENGTH_W = 5;

    // operation field of an input word
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TEXT = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    typedef enum logic [1:0] {
        KIND_REMAINDER = 2'd0,
        KIND_MATCHED   = 2'd1,
        KIND_END       = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TEXT = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [INDEX_W-1:0]          idx;
        logic signed [VALUE_W-1:0]   value;
    } cmd_t;

endpackage

### rtl/first_match_extractor.sv
// first_match_extractor: splits the first occurrence of a stored pattern out of a text stream
// steps: a load is stored in the idle state; a text word goes through POP (PASS once matched),
// then COMPARE when the window fills, then CLOSE; a match sends out the whole window before CLOSE
// the back end works on one word at a time; a command queue lets the input run ahead
// reset: async, clears window fill, matched flag and handshakes; length resets to 1;
// pattern store is undefined until loaded
module first_match_extractor #(
    parameter int MAX_PATTERN = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fme_pkg::LENGTH_W-1:0]        cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic [fme_pkg::INDEX_W-1:0]         pattern_index,
    input  logic signed [fme_pkg::VALUE_W-1:0]  element_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          result_kind,
    output logic signed [fme_pkg::VALUE_W-1:0]  result_value,
    output logic                                match_found,
    output logic                                last_of_run
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [fme_pkg::LENGTH_W-1:0] pattern_length_reg;
    logic [LW-1:0]                len;
    logic                         q_push, q_full, q_pop, q_valid;
    fme_pkg::cmd_t                push_cmd, head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= fme_pkg::LENGTH_W'(1);
        end
        else if (cfg_wr_en)
        begin
            pattern_length_reg <= cfg_wr_data;
        end
    end

    // zero acts as one, anything above the store depth as the depth
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len = LW'(1);
        end
        else if (32'(pattern_length_reg) > MAX_PATTERN)
        begin
            len = LW'(MAX_PATTERN);
        end
        else
        begin
            len = LW'(pattern_length_reg);
        end
    end

    fme_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .valid         (in_valid),
        .stall         (in_stall),
        .operation     (operation),
        .pattern_index (pattern_index),
        .element_value (element_value),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    fme_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    fme_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .len          (len),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .result_value (result_value),
        .match_found  (match_found),
        .last_of_run  (last_of_run)
    );

endmodule

### rtl/fme_front.sv
// fme_front: accepts input words, decodes the operation and folds the pattern index
// into the store depth; drops unused operations
// depends on fme_pkg
module fme_front #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                               valid,
    output logic                               stall,
    input  logic [1:0]                         operation,
    input  logic [fme_pkg::INDEX_W-1:0]        pattern_index,
    input  logic signed [fme_pkg::VALUE_W-1:0] element_value,
    input  logic                               q_full,
    output logic                               q_push,
    output fme_pkg::cmd_t                      q_cmd
);

    localparam int NUM_IDX = 2 ** fme_pkg::INDEX_W;

    logic [fme_pkg::INDEX_W-1:0] idx_mod [NUM_IDX];
    logic                        known_op;

    // index modulo store depth, worked out at elaboration
    for (genvar g = 0; g < NUM_IDX; g++) begin : g_mod
        assign idx_mod[g] = fme_pkg::INDEX_W'(g % MAX_PATTERN);
    end

    always_comb
    begin
        known_op        = 1'b1;
        q_cmd.kind      = fme_pkg::CMD_LOAD;
        q_cmd.idx       = idx_mod[pattern_index];
        q_cmd.value     = element_value;
        unique case (operation)
            fme_pkg::OP_LOAD: q_cmd.kind = fme_pkg::CMD_LOAD;
            fme_pkg::OP_TEXT: q_cmd.kind = fme_pkg::CMD_TEXT;
            fme_pkg::OP_END:  q_cmd.kind = fme_pkg::CMD_END;
            default:          known_op   = 1'b0;
        endcase
    end

    assign stall  = q_full;
    assign q_push = valid && !q_full && known_op;

endmodule

### rtl/fme_queue.sv
// fme_queue: short command queue between the front and the back
// depends on fme_pkg
module fme_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fme_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output fme_pkg::cmd_t head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fme_pkg::cmd_t   mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/fme_back.sv
// fme_back: executes commands: pattern store, text window, match check and result output
// one result is held back until the next one or the end of the command sets its last flag
// depends on fme_pkg
module fme_back #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [$clog2(MAX_PATTERN + 1)-1:0]        len,
    input  logic                                      q_valid,
    input  fme_pkg::cmd_t                             q_cmd,
    output logic                                      q_pop,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [1:0]                                result_kind,
    output logic signed [fme_pkg::VALUE_W-1:0]        result_value,
    output logic                                      match_found,
    output logic                                      last_of_run
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_POP,
        S_COMPARE,
        S_MATCH,
        S_FLUSH,
        S_ENDST,
        S_CLOSE
    } state_t;

    typedef logic signed [fme_pkg::VALUE_W-1:0] value_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   fill_reg, fill_next;
    logic            matched_reg, matched_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            out_valid_reg, out_valid_next;

    value_t          pattern_reg [MAX_PATTERN];
    value_t          pattern_next [MAX_PATTERN];
    value_t          window_reg [MAX_PATTERN];
    value_t          window_next [MAX_PATTERN];
    value_t          val_reg, val_next;

    fme_pkg::kind_t  pend_kind_reg, pend_kind_next;
    value_t          pend_value_reg, pend_value_next;
    logic            pend_found_reg, pend_found_next;
    fme_pkg::kind_t  out_kind_reg, out_kind_next;
    value_t          out_value_reg, out_value_next;
    logic            out_found_reg, out_found_next;
    logic            out_last_reg, out_last_next;

    logic            emit_req, emit_found, close_req, shift, equal;
    fme_pkg::kind_t  emit_kind;
    value_t          emit_value;
    logic            out_free, emit_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit_ok  = !pend_valid_reg || out_free;

    always_comb
    begin
        equal = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((LW'(i) < len) && (window_reg[i] != pattern_reg[i]))
            begin
                equal = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        matched_next = matched_reg;
        pattern_next = pattern_reg;
        window_next  = window_reg;
        val_next     = val_reg;
        emit_req     = 1'b0;
        emit_kind    = fme_pkg::KIND_REMAINDER;
        emit_value   = '0;
        emit_found   = 1'b0;
        close_req    = 1'b0;
        shift        = 1'b0;
        q_pop        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    val_next = q_cmd.value;
                    unique case (q_cmd.kind)
                        fme_pkg::CMD_LOAD: pattern_next[IW'(q_cmd.idx)] = q_cmd.value;
                        fme_pkg::CMD_TEXT: state_next = matched_reg ? S_PASS : S_POP;
                        fme_pkg::CMD_END:  state_next = S_FLUSH;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_PASS:
            begin
                emit_req   = 1'b1;
                emit_value = val_reg;
                emit_found = 1'b1;
                if (emit_ok)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_POP:
            begin
                // make room first, then place the new word at the tail
                if (fill_reg >= len)
                begin
                    emit_req   = 1'b1;
                    emit_value = window_reg[0];
                    if (emit_ok)
                    begin
                        shift     = 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                else
                begin
                    window_next[fill_reg[IW-1:0]] = val_reg;
                    fill_next  = fill_reg + 1'b1;
                    state_next = (fill_reg + 1'b1 == len) ? S_COMPARE : S_CLOSE;
                end
            end
            S_COMPARE:
            begin
                if (equal)
                begin
                    matched_next = 1'b1;
                    state_next   = S_MATCH;
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_MATCH:
            begin
                emit_req   = 1'b1;
                emit_kind  = fme_pkg::KIND_MATCHED;
                emit_value = window_reg[0];
                emit_found = 1'b1;
                if (emit_ok)
                begin
                    shift     = 1'b1;
                    fill_next = fill_reg - 1'b1;
                    if (fill_reg == LW'(1))
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (fill_reg != '0)
                begin
                    emit_req   = 1'b1;
                    emit_value = window_reg[0];
                    emit_found = matched_reg;
                    if (emit_ok)
                    begin
                        shift     = 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = S_ENDST;
                end
            end
            S_ENDST:
            begin
                emit_req   = 1'b1;
                emit_kind  = fme_pkg::KIND_END;
                emit_found = matched_reg;
                if (emit_ok)
                begin
                    matched_next = 1'b0;
                    state_next   = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                close_req = 1'b1;
                if (!pend_valid_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (shift)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[MAX_PATTERN - 1] = '0;
        end
    end

    // held-back result and output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_value_next = pend_value_reg;
        pend_found_next = pend_found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;

        if (emit_req && emit_ok)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = pend_kind_reg;
                out_value_next = pend_value_reg;
                out_found_next = pend_found_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = emit_kind;
            pend_value_next = emit_value;
            pend_found_next = emit_found;
        end
        else if (close_req && pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_value_next  = pend_value_reg;
            out_found_next  = pend_found_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            matched_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= fme_pkg::KIND_REMAINDER;
            out_value_reg  <= '0;
            out_found_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            matched_reg    <= matched_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_value_reg  <= out_value_next;
            out_found_reg  <= out_found_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg    <= pattern_next;
        window_reg     <= window_next;
        val_reg        <= val_next;
        pend_kind_reg  <= pend_kind_next;
        pend_value_reg <= pend_value_next;
        pend_found_reg <= pend_found_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign result_value = out_value_reg;
    assign match_found  = out_found_reg;
    assign last_of_run  = out_last_reg;

endmodule

### tb/tb_first_match_extractor.sv
`timescale 1ns / 1ps
// testbench for first_match_extractor: directed and random texts against a scoreboard
// that predicts the remainder, matched and end words; depends on fme_pkg and the rtl top

typedef struct packed {
    fme_pkg::kind_t      kind;
    logic signed [31:0]  value;
    logic                found;
    logic                last;
} split_word_t;

class split_scoreboard;
    logic signed [31:0] pattern_q [16];
    logic signed [31:0] window_q [16];
    int                 fill;
    logic               matched;
    logic [4:0]         length_reg;
    split_word_t        step_words [$];
    split_word_t        pending_words [$];
    int                 errors;
    int                 n_checked;
    int                 n_matched_words;

    function new();
        foreach (pattern_q[i]) pattern_q[i] = '0;
        foreach (window_q[i]) window_q[i] = '0;
        fill = 0;
        matched = 1'b0;
        length_reg = 5'd1;
        errors = 0;
        n_checked = 0;
        n_matched_words = 0;
    endfunction

    function void set_length(logic [4:0] v);
        length_reg = v;
    endfunction

    function int active_len();
        if (length_reg == 0)
            return 1;
        if (length_reg > 16)
            return 16;
        return int'(length_reg);
    endfunction

    function int pending();
        return pending_words.size();
    endfunction

    task report_mismatch(string msg);
        $display("error at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function void add_word(fme_pkg::kind_t k, logic signed [31:0] v, logic f);
        split_word_t w;
        w.kind = k;
        w.value = v;
        w.found = f;
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    // oldest window element leaves, the rest move up
    function logic signed [31:0] shift_out();
        logic signed [31:0] v;
        v = window_q[0];
        for (int i = 1; i < fill; i++)
            window_q[i-1] = window_q[i];
        if (fill > 0)
        begin
            fill--;
            window_q[fill] = '0;
        end
        return v;
    endfunction

    function void take_input(logic [1:0] op, logic [3:0] idx, logic signed [31:0] val);
        int          len;
        logic        equal;
        split_word_t w;
        len = active_len();
        step_words.delete();
        case (op)
            fme_pkg::OP_LOAD: pattern_q[idx] = val;
            fme_pkg::OP_TEXT:
            begin
                if (matched)
                    add_word(fme_pkg::KIND_REMAINDER, val, 1'b1);
                else
                begin
                    while (fill >= len)
                        add_word(fme_pkg::KIND_REMAINDER, shift_out(), 1'b0);
                    window_q[fill] = val;
                    fill++;
                    if (fill == len)
                    begin
                        equal = 1'b1;
                        for (int i = 0; i < len; i++)
                            if (window_q[i] != pattern_q[i])
                                equal = 1'b0;
                        if (equal)
                        begin
                            matched = 1'b1;
                            for (int i = 0; i < len; i++)
                                add_word(fme_pkg::KIND_MATCHED, window_q[i], 1'b1);
                            foreach (window_q[i]) window_q[i] = '0;
                            fill = 0;
                        end
                    end
                end
            end
            fme_pkg::OP_END:
            begin
                while (fill > 0)
                    add_word(fme_pkg::KIND_REMAINDER, shift_out(), matched);
                add_word(fme_pkg::KIND_END, '0, matched);
                matched = 1'b0;
                foreach (window_q[i]) window_q[i] = '0;
                fill = 0;
            end
            default: ;
        endcase
        foreach (step_words[i])
        begin
            w = step_words[i];
            w.last = (i == step_words.size() - 1);
            pending_words.push_back(w);
        end
    endfunction

    task check_output(logic [1:0] kind, logic signed [31:0] value, logic found,
                      logic last);
        split_word_t want;
        if (pending_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word kind %0d value %0d", kind, value));
            return;
        end
        want = pending_words.pop_front();
        n_checked++;
        if (want.kind == fme_pkg::KIND_MATCHED)
            n_matched_words++;
        if (kind !== want.kind)
            report_mismatch($sformatf("result_kind %0d, want %0d", kind, want.kind));
        if (value !== want.value)
            report_mismatch($sformatf("result_value %0d, want %0d", value, want.value));
        if (found !== want.found)
            report_mismatch($sformatf("match_found %0b, want %0b", found, want.found));
        if (last !== want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b", last, want.last));
    endtask

    task finish_check();
        if (pending_words.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", pending_words.size()));
    endtask
endclass

module tb_first_match_extractor;

    localparam logic [1:0]         OP_UNUSED    = 2'd3;
    localparam logic signed [31:0] VMIN         = 32'sh8000_0000;
    localparam logic signed [31:0] VMAX         = 32'sh7fff_ffff;
    localparam int                 DRAIN_CYCLES = 40;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [fme_pkg::LENGTH_W-1:0] cfg_wr_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [1:0]                   operation = fme_pkg::OP_LOAD;
    logic [fme_pkg::INDEX_W-1:0]  pattern_index = '0;
    logic signed [31:0]           element_value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [1:0]                   result_kind;
    logic signed [31:0]           result_value;
    logic                         match_found;
    logic                         last_of_run;

    bit                  idling_on = 1'b1;
    int                  n_items = 0;
    int                  n_texts = 0;
    split_scoreboard     sb;

    first_match_extractor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .pattern_index (pattern_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .result_value  (result_value),
        .match_found   (match_found),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: check each accepted word, then pick the next stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_output(result_kind, result_value, match_found, last_of_run);
        out_stall <= idling_on && ($urandom_range(0, 99) < 19);
    end

    task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                             input logic signed [31:0] val);
        while (idling_on && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        pattern_index <= idx;
        element_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_input(op, idx, val);
        if (op != OP_UNUSED)
            n_items++;
    endtask

    // hold the input until every expected word is out, then let the back end settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [4:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_length(v);
    endtask

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic signed [31:0] dpat [16];
        logic signed [31:0] alpha [3];
        logic signed [31:0] pat [16];
        int                 item_target;
        int                 len_code;
        int                 eff;
        int                 asize;
        int                 n_text;
        int                 at;
        int                 r;
        bit                 embed;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every pattern entry gets written before any text can compare against it
        for (int i = 0; i < 16; i++)
            dpat[i] = 32'(i * 3 + 1);
        dpat[0] = VMIN;
        dpat[1] = VMAX;
        dpat[2] = -1;
        dpat[3] = 0;
        for (int i = 0; i < 16; i++)
            send_word(fme_pkg::OP_LOAD, 4'(i), dpat[i]);

        // zero length acts as one: 5 is pushed out, then the match, then pass-through
        write_length(5'd0);
        send_word(fme_pkg::OP_TEXT, 4'd0, 5);
        send_word(fme_pkg::OP_TEXT, 4'd15, VMIN);
        send_word(fme_pkg::OP_TEXT, 4'd0, 7);
        send_word(OP_UNUSED, 4'd9, -1);
        send_word(fme_pkg::OP_END, 4'd0, 0);

        write_length(5'd3);
        send_word(fme_pkg::OP_TEXT, 4'd0, 9);
        send_word(fme_pkg::OP_TEXT, 4'd0, VMIN);
        send_word(fme_pkg::OP_TEXT, 4'd0, VMAX);
        send_word(fme_pkg::OP_TEXT, 4'd0, -1);
        send_word(fme_pkg::OP_END, 4'd0, 0);
        // tail shorter than the pattern
        send_word(fme_pkg::OP_TEXT, 4'd0, VMIN);
        send_word(fme_pkg::OP_TEXT, 4'd0, VMAX);
        send_word(fme_pkg::OP_END, 4'd0, 0);
        // load in the middle of a text keeps the window
        send_word(fme_pkg::OP_TEXT, 4'd0, 1);
        send_word(fme_pkg::OP_LOAD, 4'd15, 2);
        send_word(fme_pkg::OP_TEXT, 4'd0, 4);
        send_word(fme_pkg::OP_END, 4'd0, 0);

        // oversized length acts as the maximum, then is lowered while the window holds more than the new length
        write_length(5'd31);
        for (int i = 0; i < 5; i++)
            send_word(fme_pkg::OP_TEXT, 4'($urandom), $urandom);
        write_length(5'd2);
        send_word(fme_pkg::OP_TEXT, 4'd0, VMIN);
        send_word(fme_pkg::OP_TEXT, 4'd0, VMAX);
        send_word(fme_pkg::OP_END, 4'd0, 0);
        write_length(5'd17);
        send_word(fme_pkg::OP_TEXT, 4'd0, 0);
        send_word(fme_pkg::OP_END, 4'd0, 0);

        item_target = 300;
        while (n_items < item_target)
        begin
            n_texts++;
            idling_on <= !(n_texts >= 8 && n_texts < 16);
            r = $urandom_range(0, 99);
            if (r < 75)
                len_code = $urandom_range(1, 4);
            else if (r < 93)
                len_code = $urandom_range(5, 16);
            else if (r < 96)
                len_code = 0;
            else
                len_code = $urandom_range(17, 31);
            write_length(5'(len_code));
            eff = (len_code == 0) ? 1 : (len_code > 16) ? 16 : len_code;

            // a small alphabet makes partial and overlapping matches common
            asize = $urandom_range(1, 3);
            for (int a = 0; a < 3; a++)
                alpha[a] = $urandom_range(0, 1) ? 32'($urandom)
                                                : 32'($signed($urandom_range(0, 6)) - 3);
            for (int i = 0; i < eff; i++)
            begin
                pat[i] = alpha[$urandom_range(0, asize - 1)];
                send_word(fme_pkg::OP_LOAD, 4'(i), pat[i]);
            end

            n_text = $urandom_range(0, 2 * eff + 6);
            at = $urandom_range(0, n_text);
            embed = ($urandom_range(0, 99) < 70);
            for (int k = 0; k <= n_text; k++)
            begin
                if (embed && k == at)
                    for (int i = 0; i < eff; i++)
                        send_word(fme_pkg::OP_TEXT, 4'($urandom), pat[i]);
                if (k == n_text)
                    break;
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_word(OP_UNUSED, 4'($urandom), $urandom);
                else if (r < 6)
                    send_word(fme_pkg::OP_LOAD, 4'($urandom),
                              alpha[$urandom_range(0, asize - 1)]);
                else if (r < 8 && eff > 1)
                    write_length(5'($urandom_range(1, eff - 1)));
                else
                    send_word(fme_pkg::OP_TEXT, 4'($urandom),
                              (r < 90) ? alpha[$urandom_range(0, asize - 1)] : 32'($urandom));
            end
            if ($urandom_range(0, 9) != 0)
                send_word(fme_pkg::OP_END, 4'($urandom), $urandom);
        end
        send_word(fme_pkg::OP_END, 4'($urandom), $urandom);

        drain();
        sb.finish_check();
        $display("covered %0d input words over %0d random texts and the directed cases",
                 n_items, n_texts);
        $display("checked %0d result words, %0d of them matched elements",
                 sb.n_checked, sb.n_matched_words);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
